[sv/text_console_char_writer_unit_macros.svh]
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_CHAR_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// plain property, checked every clock outside reset
`define TCW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define TCW_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TCW_ASSERT(name, clk, rst, prop, msg)
`define TCW_ASSERT_IMPLY(name, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NEXT(name, clk, rst, ante, cons, msg)

`endif

`endif

[sv/tcw_pkg.sv]
// shared constants and controller/datapath interface types of the console writer
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // control characters
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // cell and attribute reset values
  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  ATTR_RESET = 8'd7;

  // configuration register indexes
  localparam logic REG_CHAR_ATTR = 1'b0;
  localparam logic REG_FILL_ATTR = 1'b1;

  // request functions
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // take the request and start the cell read
    logic step;      // one put step at the cursor
    logic tab_dec;   // one tab space consumed
    logic cnt_clr;   // sweep counter to zero
    logic cnt_inc;   // sweep counter advance
    logic clr_wr;    // write a blank at the sweep counter
    logic mv_rd;     // read the cell one row below the sweep counter
    logic fill_wr;   // write a fill blank into the bottom row
    logic out_load;  // load the result register
  } tcw_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_read;
    logic tab_more;
    logic step_scroll;
    logic clr_last;
    logic mv_last;
    logic fill_last;
  } tcw_stat_t;

endpackage

`default_nettype wire

[sv/tcw_ctrl.sv]
// sequencing state machine of the console writer
`default_nettype none
`include "text_console_char_writer_unit_macros.svh"

module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcw_pkg::tcw_stat_t  stat,
  output tcw_pkg::tcw_cmd_t   cmd
);
  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_MVTAIL = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_read) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.step = 1'b1;
          if (stat.step_scroll) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_SHIFT;
          end else if (stat.tab_more) begin
            cmd.tab_dec = 1'b1;
          end else if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.mv_rd = 1'b1;
        if (stat.mv_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_MVTAIL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_MVTAIL: begin
        // datapath writes the last moved cell here
        state_next = S_FILL;
      end
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.fill_last) begin
          cmd.cnt_clr = 1'b1;
          if (stat.tab_more) begin
            cmd.tab_dec = 1'b1;
            state_next  = S_EXEC;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TCW_ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == S_EXEC, "accepted request did not start")
  `TCW_ASSERT_IMPLY(a_load_free, clk, rst, cmd.out_load, !out_valid || out_ready, "result register overwritten")
  `TCW_ASSERT_IMPLY(a_result_src, clk, rst, $rose(out_valid), $past(state) == S_EXEC || $past(state) == S_FINISH, "result raised from wrong state")

endmodule

`default_nettype wire

[sv/tcw_dp.sv]
// screen memory, cursor, attributes and result register of the console writer
`default_nettype none
`include "text_console_char_writer_unit_macros.svh"

module tcw_dp #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                func,
  input  logic [7:0]          char_code,
  input  logic [4:0]          read_row,
  input  logic [6:0]          read_col,
  input  tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_stat_t  stat,
  output logic [15:0]         cell_data,
  output logic [6:0]          cursor_col,
  output logic [4:0]          cursor_row,
  output logic                scrolled
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] BOTTOM    = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLS);
  localparam logic [AW-1:0] CLR_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0] MV_LAST   = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] FILL_LAST = AW'(COLS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data;

  logic [7:0]    char_attr;
  logic [7:0]    fill_attr;
  logic          item_func;
  logic [7:0]    item_ch;
  logic          item_rd_ok;
  logic [1:0]    tab_left;
  logic          scrl;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] addr;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [AW-1:0] addr_next;

  logic [AW-1:0] cnt;
  logic          mv_pend;
  logic [AW-1:0] mv_addr;

  logic          rd_ok_in;
  logic [31:0]   rd_lin;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic          is_put;
  logic          is_lf;
  logic          is_cr;
  logic          is_tab;
  logic          printable;
  logic          col_last;
  logic          row_last;
  logic          step_scroll;
  logic          put_wr;
  logic [7:0]    put_char;
  logic [31:0]   col_ext;
  logic [31:0]   row_ext;

  // request decode
  assign is_put    = (item_func == FUNC_PUT);
  assign is_lf     = (item_ch == CH_LF);
  assign is_cr     = (item_ch == CH_CR);
  assign is_tab    = (item_ch == CH_TAB);
  assign printable = !is_lf && !is_cr && (item_ch != CH_NUL);
  assign put_char  = is_tab ? CH_SPACE : item_ch;
  assign col_last  = (col == COL_LAST);
  assign row_last  = (row == ROW_LAST);

  assign step_scroll = is_put && row_last && (is_lf || (printable && col_last));
  assign put_wr      = cmd.step && is_put && printable;

  // status
  assign stat.is_read     = (item_func == FUNC_READ);
  assign stat.tab_more    = (tab_left != 2'd0);
  assign stat.step_scroll = step_scroll;
  assign stat.clr_last    = (cnt == CLR_LAST);
  assign stat.mv_last     = (cnt == MV_LAST);
  assign stat.fill_last   = (cnt == FILL_LAST);

  // read address of a read request
  assign rd_ok_in = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLS));
  assign rd_lin   = 32'(read_row) * 32'(COLS) + 32'(read_col);

  // memory read port
  always_comb begin
    rd_en = cmd.capture || cmd.mv_rd;
    if (cmd.mv_rd) begin
      rd_addr = cnt + ROW_STEP;
    end else if (rd_ok_in) begin
      rd_addr = AW'(rd_lin);
    end else begin
      rd_addr = '0;
    end
  end

  // memory write port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = addr;
    wr_data = {char_attr, put_char};
    if (cmd.clr_wr) begin
      wr_addr = cnt;
      wr_data = BLANK_CELL;
    end else if (cmd.fill_wr) begin
      wr_addr = BOTTOM + cnt;
      wr_data = {fill_attr, CH_SPACE};
    end else if (mv_pend) begin
      wr_addr = mv_addr;
      wr_data = rd_data;
    end else if (!put_wr) begin
      wr_en = 1'b0;
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // cursor update for one put step
  always_comb begin
    col_next  = col;
    row_next  = row;
    addr_next = addr;
    if (cmd.step && is_put) begin
      if (is_lf) begin
        if (row_last) begin
          col_next  = '0;
          addr_next = BOTTOM;
        end else begin
          row_next  = row + RW'(1);
          addr_next = addr + ROW_STEP;
        end
      end else if (is_cr) begin
        col_next  = '0;
        addr_next = addr - AW'(col);
      end else if (printable) begin
        if (!col_last) begin
          col_next  = col + CW'(1);
          addr_next = addr + AW'(1);
        end else if (row_last) begin
          col_next  = '0;
          addr_next = BOTTOM;
        end else begin
          col_next  = '0;
          row_next  = row + RW'(1);
          addr_next = addr + AW'(1);
        end
      end
    end
  end

  assign col_ext = 32'(col_next);
  assign row_ext = 32'(row_next);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      char_attr <= ATTR_RESET;
      fill_attr <= ATTR_RESET;
      col       <= '0;
      row       <= '0;
      addr      <= '0;
      cnt       <= '0;
      mv_pend   <= 1'b0;
      tab_left  <= 2'd0;
      scrl      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHAR_ATTR: char_attr <= cfg_data;
          REG_FILL_ATTR: fill_attr <= cfg_data;
        endcase
      end
      col     <= col_next;
      row     <= row_next;
      addr    <= addr_next;
      mv_pend <= cmd.mv_rd;
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.capture) begin
        tab_left <= (func == FUNC_PUT && char_code == CH_TAB) ? 2'd2 : 2'd0;
        scrl     <= 1'b0;
      end else begin
        if (cmd.tab_dec) begin
          tab_left <= tab_left - 2'd1;
        end
        if (cmd.step && step_scroll) begin
          scrl <= 1'b1;
        end
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    mv_addr <= cnt;
    if (cmd.capture) begin
      item_func  <= func;
      item_ch    <= char_code;
      item_rd_ok <= rd_ok_in;
    end
    if (cmd.out_load) begin
      cell_data  <= (item_func == FUNC_READ && item_rd_ok) ? rd_data : 16'd0;
      cursor_col <= col_ext[6:0];
      cursor_row <= row_ext[4:0];
      scrolled   <= scrl;
    end
  end

  `TCW_ASSERT(a_wr_single, clk, rst, $onehot0({cmd.clr_wr, cmd.fill_wr, mv_pend, put_wr}), "write port conflict")
  `TCW_ASSERT(a_addr_match, clk, rst, 32'(addr) == 32'(row) * 32'(COLS) + 32'(col), "cursor address out of step")
  `TCW_ASSERT(a_row_range, clk, rst, 32'(row) < 32'(ROWS), "cursor row past bottom")

endmodule

`default_nettype wire

[sv/text_console_char_writer_unit.sv]
// Text console character writer: screen of ROWS x COLS cells with a cursor.
// Put or read: a new request is taken only once the result of the last one is loaded; a tab puts three spaces.
// A scroll moves the screen through the memory's read and write ports, one cell per cycle:
// each row below the top moves up one row, then the bottom row is filled with fill-attribute blanks.
// Reset: a clearing pass writes blanks over all ROWS*COLS cells
// with in_ready low; configuration writes are taken throughout.
`default_nettype none

module text_console_char_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  char_code,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_data,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic        scrolled
);
  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // sequencing
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // screen and cursor datapath
  tcw_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .cmd        (cmd),
    .stat       (stat),
    .cell_data  (cell_data),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .scrolled   (scrolled)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
// self-checking testbench for the console character writer: predictor, scoreboard, traffic
`timescale 1ns / 100ps

import tcw_pkg::*;

localparam int SCREEN_COLS = COLS_DEF;
localparam int SCREEN_ROWS = ROWS_DEF;

// one result as seen on the output port
typedef struct packed {
  logic [15:0] cell_word;
  logic [6:0]  col;
  logic [4:0]  row;
  logic        scrolled;
} console_result_t;

// screen and cursor predictor with the queue of results still owed by the block
class console_scoreboard;
  logic [15:0] screen [SCREEN_ROWS][SCREEN_COLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0] char_attr;
  logic [7:0] fill_attr;
  console_result_t pending_results[$];
  int mismatch_count;

  function new();
    for (int r = 0; r < SCREEN_ROWS; r++)
      for (int c = 0; c < SCREEN_COLS; c++)
        screen[r][c] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
    char_attr = ATTR_RESET;
    fill_attr = ATTR_RESET;
    mismatch_count = 0;
  endfunction

  function void set_register(logic idx, logic [7:0] value);
    if (idx == REG_CHAR_ATTR) char_attr = value;
    else fill_attr = value;
  endfunction

  // move everything up one row once the cursor has run past the bottom
  function bit scroll_up();
    if (cur_row < SCREEN_ROWS) return 1'b0;
    for (int r = 0; r < SCREEN_ROWS - 1; r++)
      for (int c = 0; c < SCREEN_COLS; c++)
        screen[r][c] = screen[r + 1][c];
    for (int c = 0; c < SCREEN_COLS; c++)
      screen[SCREEN_ROWS - 1][c] = {fill_attr, CH_SPACE};
    cur_row = SCREEN_ROWS - 1;
    cur_col = 0;
    return 1'b1;
  endfunction

  // write at the cursor, advance and wrap
  function bit put_plain(logic [7:0] ch);
    screen[cur_row][cur_col] = {char_attr, ch};
    if (cur_col + 1 < SCREEN_COLS) begin
      cur_col++;
      return 1'b0;
    end
    cur_col = 0;
    cur_row++;
    return scroll_up();
  endfunction

  // update the screen for one accepted request and queue its result
  function void note_request(logic f, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    console_result_t res;
    res = '0;
    if (f == FUNC_READ) begin
      if (rr < SCREEN_ROWS && rc < SCREEN_COLS) res.cell_word = screen[rr][rc];
    end else begin
      case (ch)
        CH_LF: begin
          cur_row++;
          res.scrolled = scroll_up();
        end
        CH_CR: cur_col = 0;
        CH_TAB: begin
          for (int k = 0; k < 3; k++)
            if (put_plain(CH_SPACE)) res.scrolled = 1'b1;
        end
        CH_NUL: ;
        default: res.scrolled = put_plain(ch);
      endcase
    end
    res.col = cur_col[6:0];
    res.row = cur_row[4:0];
    pending_results.push_back(res);
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // compare one result with the oldest expectation
  task check_result(console_result_t got);
    console_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", 32'(got), 32'd0);
      return;
    end
    want = pending_results.pop_front();
    if (got.cell_word !== want.cell_word)
      report_mismatch("cell_data", 32'(got.cell_word), 32'(want.cell_word));
    if (got.col !== want.col) report_mismatch("cursor_col", 32'(got.col), 32'(want.col));
    if (got.row !== want.row) report_mismatch("cursor_row", 32'(got.row), 32'(want.row));
    if (got.scrolled !== want.scrolled)
      report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
  endtask
endclass

module tb;

  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_CHAR_ATTR;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_PUT;
  logic [7:0]  char_code = CH_NUL;
  logic [4:0]  read_row = 5'd0;
  logic [6:0]  read_col = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cell_data;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        scrolled;

  console_scoreboard sb = new();
  bit idle_on = 1'b1;
  int items_sent = 0;
  int stall_left = 0;

  text_console_char_writer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .char_code(char_code), .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_data(cell_data), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .scrolled(scrolled)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stalls in random bursts while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({cell_data, cursor_col, cursor_row, scrolled});
  end

  // run limit
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // one request, with an occasional gap ahead of it
  task automatic send_request(logic f, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    char_code <= ch;
    read_row <= rr;
    read_col <= rc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(f, ch, rr, rc);
    if (!(f == FUNC_PUT && ch == CH_NUL)) items_sent++;
  endtask

  // read a cell, mostly on screen, sometimes on the cursor row, sometimes anywhere
  task automatic send_read();
    logic [4:0] rr;
    logic [6:0] rc;
    case ($urandom_range(0, 4))
      0: begin
        rr = 5'($urandom);
        rc = 7'($urandom);
      end
      1: begin
        rr = 5'(sb.cur_row);
        rc = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
      default: begin
        rr = 5'($urandom_range(0, SCREEN_ROWS - 1));
        rc = 7'($urandom_range(0, SCREEN_COLS - 1));
      end
    endcase
    send_request(FUNC_READ, 8'($urandom), rr, rc);
  endtask

  // a line of text with reads mixed in, closed by some mix of return and newlines
  task automatic send_line();
    int len;
    int ending;
    logic [7:0] ch;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 5) == 0) send_read();
      case ($urandom_range(0, 9))
        0: ch = CH_TAB;
        1: ch = 8'($urandom_range(128, 255));
        default: ch = 8'($urandom_range(32, 126));
      endcase
      send_request(FUNC_PUT, ch, 5'($urandom), 7'($urandom));
    end
    ending = $urandom_range(0, 3);
    if (ending != 1) send_request(FUNC_PUT, CH_CR, 5'($urandom), 7'($urandom));
    if (ending == 2) begin
      repeat ($urandom_range(2, 6)) send_request(FUNC_PUT, CH_LF, 5'($urandom), 7'($urandom));
    end else if (ending != 0) begin
      send_request(FUNC_PUT, CH_LF, 5'($urandom), 7'($urandom));
    end
  endtask

  // mostly well-formed lines, the rest fully random requests
  task automatic run_traffic(int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0)
        send_request(1'($urandom), 8'($urandom), 5'($urandom), 7'($urandom));
      else send_line();
    end
  endtask

  // hold off requests until every result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_attributes(logic [7:0] chr, logic [7:0] fill);
    cfg_we <= 1'b1;
    cfg_index <= REG_CHAR_ATTR;
    cfg_data <= chr;
    @(posedge clk);
    cfg_index <= REG_FILL_ATTR;
    cfg_data <= fill;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(REG_CHAR_ATTR, chr);
    sb.set_register(REG_FILL_ATTR, fill);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: reads at the screen corners and off screen, then each kind of put, then reads back
    send_request(FUNC_READ, CH_NUL, 5'd0, 7'd0);
    send_request(FUNC_READ, CH_NUL, 5'd24, 7'd79);
    send_request(FUNC_READ, CH_NUL, 5'd25, 7'd0);
    send_request(FUNC_READ, CH_NUL, 5'd0, 7'd80);
    send_request(FUNC_READ, 8'hff, 5'd31, 7'd127);
    send_request(FUNC_PUT, 8'h41, 5'd0, 7'd0);
    send_request(FUNC_PUT, 8'hff, 5'd31, 7'd127);
    send_request(FUNC_PUT, 8'h80, 5'd0, 7'd0);
    send_request(FUNC_PUT, 8'h01, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_NUL, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_SPACE, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_LF, 5'd0, 7'd0);
    send_request(FUNC_PUT, 8'h7e, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_CR, 5'd0, 7'd0);
    send_request(FUNC_PUT, CH_LF, 5'd0, 7'd0);
    send_request(FUNC_READ, CH_NUL, 5'd0, 7'd0);
    send_request(FUNC_READ, CH_NUL, 5'd0, 7'd1);
    send_request(FUNC_READ, CH_NUL, 5'd0, 7'd6);
    send_request(FUNC_READ, CH_NUL, 5'd1, 7'd7);

    // random phases, each under its own attribute setting
    wait_for_results();
    write_attributes(8'h00, 8'hff);
    run_traffic(200);
    wait_for_results();
    write_attributes(8'hff, 8'h00);
    run_traffic(200);
    wait_for_results();
    write_attributes(8'($urandom), 8'($urandom));
    run_traffic(200);
    wait_for_results();
    write_attributes(8'($urandom), 8'($urandom));
    idle_on = 1'b0;
    run_traffic(200);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[text_console_char_writer_unit.f]
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_char_writer_unit.sv
bench/tb.sv
